/* sv/smq_pkg.sv */
// smq_pkg: shared types and codes for the stack with median query block
// item structs for both channels, command and status codes, fixed field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package smq_pkg;

    localparam int KEY_W    = 10;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MEDIAN = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key_value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    out_value;
    } t_out_item;

endpackage

`default_nettype wire

/* sv/smq_ram.sv */
// smq_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module smq_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/stack_with_median_query_core.sv */
// stack_with_median_query_core: stack of keys with a median query over a fenwick count tree
// depends on smq_pkg and smq_ram
`timescale 1ns / 1ps
`default_nettype none

// A stack of keys (1 .. 2^KEY_BITS-1) that also reports the median of the keys it holds.
// Each input transfer carries one command: push (no result unless the stack is full,
// then status 2), pop (returns the top key) or median (returns the smallest key whose
// count prefix reaches (size+1)/2); pop or median on an empty stack returns status 1.
// Pushes of key zero and the unused command code are dropped with no result. Per-key
// counts live in a fenwick tree held in one ram that a small sequencer walks, each tree
// node taking a ram read and then a compare or read-modify-write, so the memory port
// sets the pace: push and pop visit the nodes on the update path (at most KEY_BITS),
// pop after reading the top key, and median probes KEY_BITS nodes on its descent; empty
// or full cases go straight to the result. A result that finds the output register
// still held by a stalled earlier result keeps the block in its final state until that
// register frees. The block takes one item at a time and holds stall high while it
// works. After reset the count tree is cleared one entry a cycle, and input stall stays
// high until every entry is cleared. A result waits in an output register, so the block
// is free for a new item once the result is stored there.

module stack_with_median_query_core #(
    parameter int KEY_BITS    = 10,
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire smq_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output smq_pkg::t_out_item    o_out_data
);

    localparam int KB       = smq_pkg::KEY_W;
    localparam int CW       = $clog2(STACK_DEPTH + 1);   // stack size and tree counts
    localparam int SAW      = $clog2(STACK_DEPTH);       // stack address
    localparam int TREE_DEP = 1 << KEY_BITS;

    // sequencer states
    localparam logic [2:0] S_CLR     = 3'd0;   // clearing sweep after reset
    localparam logic [2:0] S_IDLE    = 3'd1;   // ready for a transfer
    localparam logic [2:0] S_POP     = 3'd2;   // top of stack arrives from ram
    localparam logic [2:0] S_UPD_RD  = 3'd3;   // read tree node on update path
    localparam logic [2:0] S_UPD_WR  = 3'd4;   // write node back +/- 1, step up
    localparam logic [2:0] S_MED_RD  = 3'd5;   // read probe node of descent
    localparam logic [2:0] S_MED_CMP = 3'd6;   // compare against remaining need
    localparam logic [2:0] S_EMIT    = 3'd7;   // move result into output register

    logic [2:0]          r_state,      n_state;
    logic [CW-1:0]       r_count,      n_count;
    logic                r_up,         n_up;
    logic [KEY_BITS:0]   r_idx,        n_idx;
    logic [KEY_BITS-1:0] r_pos,        n_pos;
    logic [KEY_BITS-1:0] r_step,       n_step;
    logic [CW-1:0]       r_need,       n_need;
    logic [KEY_BITS-1:0] r_clr_idx,    n_clr_idx;
    smq_pkg::t_out_item  r_res,        n_res;
    logic                r_out_valid,  n_out_valid;
    smq_pkg::t_out_item  r_out_data,   n_out_data;

    // tree ram port
    logic                t_we;
    logic [KEY_BITS-1:0] t_waddr;
    logic [CW-1:0]       t_wdata;
    logic [KEY_BITS-1:0] t_raddr;
    logic [CW-1:0]       t_rdata;

    // stack ram port
    logic                s_we;
    logic [SAW-1:0]      s_waddr;
    logic [KEY_BITS-1:0] s_wdata;
    logic [SAW-1:0]      s_raddr;
    logic [KEY_BITS-1:0] s_rdata;

    // key field resized to KEY_BITS, upper input bits dropped if narrower
    logic [KEY_BITS+KB-1:0] in_key_wide;
    logic [KEY_BITS-1:0]    in_key;
    assign in_key_wide = {{KEY_BITS{1'b0}}, i_in_data.key_value};
    assign in_key      = in_key_wide[KEY_BITS-1:0];

    // helpers for the datapath
    logic [CW-1:0]       count_dec;
    logic [CW:0]         count_inc_wide;
    logic [KEY_BITS:0]   idx_lowbit;
    logic [KEY_BITS:0]   idx_next;
    logic [KEY_BITS-1:0] probe;
    logic [KEY_BITS-1:0] med_pos;
    logic [KEY_BITS-1:0] med_key;
    logic [KEY_BITS+KB-1:0] med_key_wide;
    logic [KEY_BITS+KB-1:0] pop_key_wide;
    logic                accept;
    logic                out_free;

    assign count_dec      = r_count - CW'(1);
    assign count_inc_wide = {1'b0, r_count} + (CW+1)'(1);
    assign idx_lowbit     = r_idx & (~r_idx + (KEY_BITS+1)'(1));
    assign idx_next       = r_idx + idx_lowbit;
    // pos only holds bits above step, so or equals the sum
    assign probe          = r_pos | r_step;
    assign med_pos        = (t_rdata < r_need) ? probe : r_pos;
    assign med_key        = med_pos + KEY_BITS'(1);
    assign med_key_wide   = {{KB{1'b0}}, med_key};
    assign pop_key_wide   = {{KB{1'b0}}, s_rdata};

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    // output register can take a new result when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    // stack ram: push writes at the current size, the top is always being read
    assign s_we    = accept && (i_in_data.cmd == smq_pkg::CMD_PUSH) && (in_key != '0)
                     && (r_count != CW'(STACK_DEPTH));
    assign s_waddr = r_count[SAW-1:0];
    assign s_wdata = in_key;
    assign s_raddr = count_dec[SAW-1:0];

    // tree ram: clearing sweep or node write-back; reads for update or descent
    always_comb begin
        t_we    = 1'b0;
        t_waddr = r_idx[KEY_BITS-1:0];
        t_wdata = r_up ? (t_rdata + CW'(1)) : (t_rdata - CW'(1));
        t_raddr = r_idx[KEY_BITS-1:0];
        case (r_state)
            S_CLR: begin
                t_we    = 1'b1;
                t_waddr = r_clr_idx;
                t_wdata = '0;
            end
            S_UPD_WR: begin
                t_we = 1'b1;
            end
            S_MED_RD: begin
                t_raddr = probe;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_up      = r_up;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_step    = r_step;
        n_need    = r_need;
        n_clr_idx = r_clr_idx;
        n_res     = r_res;
        case (r_state)
            S_CLR: begin
                n_clr_idx = r_clr_idx + KEY_BITS'(1);
                if (r_clr_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.cmd)
                        smq_pkg::CMD_PUSH: begin
                            if (in_key == '0) begin
                                n_state = S_IDLE;
                            end else if (r_count == CW'(STACK_DEPTH)) begin
                                n_res.status    = smq_pkg::STAT_FULL;
                                n_res.out_value = '0;
                                n_state         = S_EMIT;
                            end else begin
                                n_count = r_count + CW'(1);
                                n_idx   = {1'b0, in_key};
                                n_up    = 1'b1;
                                n_state = S_UPD_RD;
                            end
                        end
                        smq_pkg::CMD_POP: begin
                            if (r_count == '0) begin
                                n_res.status    = smq_pkg::STAT_EMPTY;
                                n_res.out_value = '0;
                                n_state         = S_EMIT;
                            end else begin
                                // ram is already reading the top entry
                                n_count = count_dec;
                                n_state = S_POP;
                            end
                        end
                        smq_pkg::CMD_MEDIAN: begin
                            if (r_count == '0) begin
                                n_res.status    = smq_pkg::STAT_EMPTY;
                                n_res.out_value = '0;
                                n_state         = S_EMIT;
                            end else begin
                                n_need  = count_inc_wide[CW:1];
                                n_pos   = '0;
                                n_step  = {1'b1, {(KEY_BITS-1){1'b0}}};
                                n_state = S_MED_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_idx           = {1'b0, s_rdata};
                n_up            = 1'b0;
                n_res.status    = smq_pkg::STAT_OK;
                n_res.out_value = pop_key_wide[KB-1:0];
                n_state         = S_UPD_RD;
            end
            S_UPD_RD: begin
                n_state = S_UPD_WR;
            end
            S_UPD_WR: begin
                n_idx = idx_next;
                if (idx_next[KEY_BITS] || (idx_next == '0)) begin
                    // walked off the top of the tree
                    n_state = r_up ? S_IDLE : S_EMIT;
                end else begin
                    n_state = S_UPD_RD;
                end
            end
            S_MED_RD: begin
                n_state = S_MED_CMP;
            end
            S_MED_CMP: begin
                n_pos  = med_pos;
                n_step = r_step >> 1;
                if (t_rdata < r_need) begin
                    n_need = r_need - t_rdata;
                end
                if (r_step[0]) begin
                    n_res.status    = smq_pkg::STAT_OK;
                    n_res.out_value = med_key_wide[KB-1:0];
                    n_state         = S_EMIT;
                end else begin
                    n_state = S_MED_RD;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register: loaded from the result holding register, drained by transfer
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == S_EMIT) && out_free) begin
            n_out_valid = 1'b1;
            n_out_data  = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_count     <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_up       <= n_up;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_step     <= n_step;
        r_need     <= n_need;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    smq_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    smq_ram #(
        .WIDTH (CW),
        .DEPTH (TREE_DEP)
    ) u_tree_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* sv/smq_checker.sv */
// smq_checker: port-level assertions for stack_with_median_query_core
// depends on smq_pkg; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

module smq_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire smq_pkg::t_in_item  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire smq_pkg::t_out_item o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // error results carry a zero value and a known status
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != smq_pkg::STAT_OK))
            |-> ((o_out_data.out_value == '0) && (o_out_data.status != smq_pkg::STAT_BAD)))
        else $error("error result with nonzero value or bad status");

    // a new result only appears while the block was busy with an item
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while idle");

    // pop and median always keep the block busy for the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && ((i_in_data.cmd == smq_pkg::CMD_POP)
            || (i_in_data.cmd == smq_pkg::CMD_MEDIAN))) |=> o_in_stall)
        else $error("block idle right after pop or median transfer");

endmodule

bind stack_with_median_query_core smq_checker u_smq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
